// ===== src/fluti_pkg.sv =====
// fluti_pkg: shared types and constants for the fluence table interpolator
// no dependencies; imported by fluti_interp, the top level and the testbench
`default_nettype none

package fluti_pkg;

    localparam int DEF_POINTS      = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int IDX_W = 4;
    localparam int CNT_W = 5;

    localparam logic [CNT_W-1:0] CNT_RESET = 5'd2;
    localparam logic [CNT_W-1:0] CNT_MIN   = 5'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STAT_WRITE = 2'd0,
        STAT_QUERY = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CTL_IDLE,
        CTL_LAST,
        CTL_FIRST,
        CTL_SCAN,
        CTL_CALC,
        CTL_DONE
    } t_ctl_state;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_MUL,
        LN_OVF,
        LN_DIV,
        LN_FIN
    } t_lane_state;

endpackage

`default_nettype wire

// ===== src/fluti_ram.sv =====
// fluti_ram: generic single-port synchronous ram, registered read
// no dependencies
`default_nettype none

module fluti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/fluti_interp.sv =====
// fluti_interp: one interpolation lane, shift-add multiply then restoring divide
// depends on fluti_pkg
`default_nettype none

module fluti_interp
    import fluti_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic signed [VALUE_WIDTH-1:0] i_y0,
    input  wire logic signed [VALUE_WIDTH-1:0] i_y1,
    input  wire logic signed [VALUE_WIDTH-1:0] i_x0,
    input  wire logic signed [VALUE_WIDTH-1:0] i_x1,
    input  wire logic signed [VALUE_WIDTH-1:0] i_q,
    output logic                               o_done,
    output logic signed [VALUE_WIDTH-1:0]      o_result
);

    localparam int VW = VALUE_WIDTH;
    localparam int W  = VW + 1;
    localparam int CW = $clog2(W + 1);
    localparam int SW = W + 2;

    function automatic logic [W-1:0] magw(input logic [W-1:0] v);
        magw = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    t_lane_state r_state, n_state;
    logic        r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;

    logic [W-1:0]  r_a, n_a;
    logic [W-1:0]  r_d, n_d;
    logic [W-1:0]  r_hi, n_hi;
    logic [W-1:0]  r_lo, n_lo;
    logic [W-1:0]  r_rem, n_rem;
    logic          r_neg, n_neg;
    logic          r_dxz, n_dxz;
    logic          r_ovf, n_ovf;
    logic signed [VW-1:0] r_y0, n_y0;
    logic signed [VW-1:0] r_result, n_result;

    logic [W-1:0]  dy, dq, dx;
    logic [W:0]    mul_sum;
    logic [W:0]    div_t;
    logic [W:0]    div_diff;
    logic          div_ge;
    logic [W-1:0]  quo;
    logic [SW-1:0] y0_x, quo_x, acc;
    logic          acc_fits;

    assign dy = {i_y1[VW-1], i_y1} - {i_y0[VW-1], i_y0};
    assign dq = {i_q[VW-1], i_q} - {i_x0[VW-1], i_x0};
    assign dx = {i_x1[VW-1], i_x1} - {i_x0[VW-1], i_x0};

    assign mul_sum  = {1'b0, r_hi} + {1'b0, (r_lo[0] ? r_a : {W{1'b0}})};
    assign div_t    = {r_rem, r_lo[W-1]};
    assign div_ge   = div_t >= {1'b0, r_d};
    assign div_diff = div_t - {1'b0, r_d};

    assign quo      = r_ovf ? {W{1'b1}} : r_lo;
    assign y0_x     = {{(SW-VW){r_y0[VW-1]}}, r_y0};
    assign quo_x    = {2'b00, quo};
    assign acc      = r_neg ? (y0_x - quo_x) : (y0_x + quo_x);
    assign acc_fits = (acc[SW-1:VW-1] == '0) || (acc[SW-1:VW-1] == '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LN_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_a      <= n_a;
        r_d      <= n_d;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_rem    <= n_rem;
        r_neg    <= n_neg;
        r_dxz    <= n_dxz;
        r_ovf    <= n_ovf;
        r_y0     <= n_y0;
        r_result <= n_result;
    end

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_a      = r_a;
        n_d      = r_d;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_rem    = r_rem;
        n_neg    = r_neg;
        n_dxz    = r_dxz;
        n_ovf    = r_ovf;
        n_y0     = r_y0;
        n_result = r_result;
        case (r_state)
            LN_IDLE: begin
                if (i_start) begin
                    n_a     = magw(dy);
                    n_lo    = magw(dq);
                    n_d     = magw(dx);
                    n_hi    = '0;
                    n_neg   = dy[W-1] ^ dq[W-1] ^ dx[W-1];
                    n_dxz   = (dx == '0);
                    n_y0    = i_y0;
                    n_cnt   = '0;
                    n_state = LN_MUL;
                end
            end
            LN_MUL: begin
                n_hi  = mul_sum[W:1];
                n_lo  = {mul_sum[0], r_lo[W-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    n_state = LN_OVF;
                end
            end
            LN_OVF: begin
                // quotient wider than W bits saturates the sum anyway
                n_ovf   = r_hi >= r_d;
                n_rem   = r_hi;
                n_cnt   = '0;
                n_state = LN_DIV;
            end
            LN_DIV: begin
                n_rem = div_ge ? div_diff[W-1:0] : div_t[W-1:0];
                n_lo  = {r_lo[W-2:0], div_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    n_state = LN_FIN;
                end
            end
            LN_FIN: begin
                if (r_dxz || (quo == '0)) begin
                    n_result = r_y0;
                end else if (acc_fits) begin
                    n_result = acc[VW-1:0];
                end else if (acc[SW-1]) begin
                    n_result = {1'b1, {(VW-1){1'b0}}};
                end else begin
                    n_result = {1'b0, {(VW-1){1'b1}}};
                end
                n_done  = 1'b1;
                n_state = LN_IDLE;
            end
            default: begin
                n_state = LN_IDLE;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== src/fluence_table_interpolator_unit.sv =====
// fluence_table_interpolator_unit: breakpoint table with piecewise linear lookup
// depends on fluti_pkg, fluti_ram, fluti_interp
//
// channel  dir  tdata (low bit up)                                   tuser
// s_axis   in   point_index, point_fluence, point_production,        cmd
//               point_destruction, point_burnup, query_fluence
// m_axis   out  burnup_out, production_out, destruction_out          beyond_range, status
// cfg      in   point_count (5 bits)                                 -
//
// a write goes to the done state, then the result register; a query at or past the
// last point first passes the last check; other queries read one table row per cycle
// in the search, then the three lanes each run VALUE_WIDTH+1 multiply steps and
// VALUE_WIDTH+1 divide steps
// synchronous reset: point_count returns to 2, table contents stay undefined
// one result register: the next item is taken while a result waits on m_axis
`default_nettype none

module fluence_table_interpolator_unit
    import fluti_pkg::*;
#(
    parameter int POINTS      = DEF_POINTS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic                                                i_clk,
    input  wire logic                                                i_rst_n,
    input  wire logic                                                i_s_axis_tvalid,
    output logic                                                     o_s_axis_tready,
    // point_index, point_fluence, point_production, point_destruction,
    // point_burnup, query_fluence
    input  wire logic [((IDX_W + 5 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // cmd
    input  wire logic                                                i_s_axis_tuser,
    output logic                                                     o_m_axis_tvalid,
    input  wire logic                                                i_m_axis_tready,
    // burnup_out, production_out, destruction_out
    output logic [((3 * VALUE_WIDTH + 7) / 8) * 8 - 1:0]             o_m_axis_tdata,
    // beyond_range, status
    output logic [2:0]                                               o_m_axis_tuser,
    input  wire logic                                                i_cfg_valid,
    output logic                                                     o_cfg_ready,
    input  wire logic [CNT_W-1:0]                                    i_cfg_data
);

    localparam int VW    = VALUE_WIDTH;
    localparam int AW    = $clog2(POINTS);
    localparam int EW    = 4 * VW;
    localparam int OUT_W = ((3 * VW + 7) / 8) * 8;
    localparam int NMAX  = (POINTS < 31) ? POINTS : 31;
    localparam logic [CNT_W-1:0] NMAX_C = CNT_W'(NMAX);

    t_ctl_state r_state, n_state;
    logic [CNT_W-1:0] r_point_count;
    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_data, n_out_data;
    logic [2:0]       r_out_user, n_out_user;

    t_status          r_status, n_status;
    logic             r_flag, n_flag;
    logic [CNT_W-1:0] r_seg, n_seg;
    logic [EW-1:0]    r_lo, n_lo;
    logic signed [VW-1:0] r_q, n_q;
    logic signed [VW-1:0] r_bu, n_bu;
    logic signed [VW-1:0] r_pr, n_pr;
    logic signed [VW-1:0] r_de, n_de;

    logic [CNT_W-1:0] used, last, seg_inc;
    logic             in_xfer;
    logic [IDX_W-1:0] in_idx;
    logic signed [VW-1:0] in_pf, in_pp, in_pd, in_pb, in_qf;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [EW-1:0] ram_wdata, ram_rdata;
    logic signed [VW-1:0] rd_f, rd_p, rd_d, rd_b;
    logic signed [VW-1:0] lo_f, lo_p, lo_d, lo_b;

    logic          lane_start;
    logic [2:0]    lane_done;
    logic signed [VW-1:0] lane_bu, lane_pr, lane_de;
    logic signed [VW-1:0] fmt_bu, fmt_pr, fmt_de;

    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign in_idx  = i_s_axis_tdata[IDX_W-1:0];
    assign in_pf   = i_s_axis_tdata[IDX_W +: VW];
    assign in_pp   = i_s_axis_tdata[IDX_W + VW +: VW];
    assign in_pd   = i_s_axis_tdata[IDX_W + 2 * VW +: VW];
    assign in_pb   = i_s_axis_tdata[IDX_W + 3 * VW +: VW];
    assign in_qf   = i_s_axis_tdata[IDX_W + 4 * VW +: VW];

    assign rd_f = ram_rdata[0 +: VW];
    assign rd_p = ram_rdata[VW +: VW];
    assign rd_d = ram_rdata[2 * VW +: VW];
    assign rd_b = ram_rdata[3 * VW +: VW];
    assign lo_f = r_lo[0 +: VW];
    assign lo_p = r_lo[VW +: VW];
    assign lo_d = r_lo[2 * VW +: VW];
    assign lo_b = r_lo[3 * VW +: VW];

    always_comb begin
        if (r_point_count < CNT_MIN) begin
            used = CNT_MIN;
        end else if (r_point_count > NMAX_C) begin
            used = NMAX_C;
        end else begin
            used = r_point_count;
        end
    end

    assign last    = used - CNT_W'(1);
    assign seg_inc = r_seg + CNT_W'(1);

    fluti_ram #(
        .WIDTH (EW),
        .DEPTH (POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    fluti_interp #(.VALUE_WIDTH(VW)) u_lane_bu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (lane_start),
        .i_y0     (lo_b),
        .i_y1     (rd_b),
        .i_x0     (lo_f),
        .i_x1     (rd_f),
        .i_q      (r_q),
        .o_done   (lane_done[0]),
        .o_result (lane_bu)
    );

    fluti_interp #(.VALUE_WIDTH(VW)) u_lane_pr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (lane_start),
        .i_y0     (lo_p),
        .i_y1     (rd_p),
        .i_x0     (lo_f),
        .i_x1     (rd_f),
        .i_q      (r_q),
        .o_done   (lane_done[1]),
        .o_result (lane_pr)
    );

    fluti_interp #(.VALUE_WIDTH(VW)) u_lane_de (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (lane_start),
        .i_y0     (lo_d),
        .i_y1     (rd_d),
        .i_x0     (lo_f),
        .i_x1     (rd_f),
        .i_q      (r_q),
        .o_done   (lane_done[2]),
        .o_result (lane_de)
    );

    // sign rules on the query fluence
    always_comb begin
        fmt_bu = r_bu;
        fmt_pr = r_pr;
        fmt_de = r_de;
        if (r_status == STAT_QUERY) begin
            if (r_q <= 0) begin
                fmt_bu = '0;
            end
            if (r_q < 0) begin
                fmt_pr = '0;
                fmt_de = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= CTL_IDLE;
            r_point_count <= CNT_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_point_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_status   <= n_status;
        r_flag     <= n_flag;
        r_seg      <= n_seg;
        r_lo       <= n_lo;
        r_q        <= n_q;
        r_bu       <= n_bu;
        r_pr       <= n_pr;
        r_de       <= n_de;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_status    = r_status;
        n_flag      = r_flag;
        n_seg       = r_seg;
        n_lo        = r_lo;
        n_q         = r_q;
        n_bu        = r_bu;
        n_pr        = r_pr;
        n_de        = r_de;
        ram_we      = 1'b0;
        ram_addr    = AW'(last);
        ram_wdata   = {in_pb, in_pd, in_pp, in_pf};
        lane_start  = 1'b0;
        case (r_state)
            CTL_IDLE: begin
                if (in_xfer) begin
                    if (i_s_axis_tuser == CMD_WRITE) begin
                        n_bu   = '0;
                        n_pr   = '0;
                        n_de   = '0;
                        n_flag = 1'b0;
                        if ({1'b0, in_idx} < used) begin
                            ram_we   = 1'b1;
                            ram_addr = AW'(in_idx);
                            n_status = STAT_WRITE;
                        end else begin
                            n_status = STAT_RANGE;
                        end
                        n_state = CTL_DONE;
                    end else begin
                        n_q      = in_qf;
                        n_status = STAT_QUERY;
                        n_state  = CTL_LAST;
                    end
                end
            end
            CTL_LAST: begin
                n_flag = r_q >= rd_f;
                if (r_q >= rd_f) begin
                    n_bu    = rd_b;
                    n_pr    = rd_p;
                    n_de    = rd_d;
                    n_state = CTL_DONE;
                end else begin
                    ram_addr = '0;
                    n_state  = CTL_FIRST;
                end
            end
            CTL_FIRST: begin
                n_lo     = ram_rdata;
                n_seg    = CNT_W'(1);
                ram_addr = AW'(1);
                n_state  = CTL_SCAN;
            end
            CTL_SCAN: begin
                if ((r_seg < last) && (rd_f <= r_q)) begin
                    n_lo     = ram_rdata;
                    n_seg    = seg_inc;
                    ram_addr = AW'(seg_inc);
                end else begin
                    lane_start = 1'b1;
                    n_state    = CTL_CALC;
                end
            end
            CTL_CALC: begin
                if (lane_done[0]) begin
                    n_bu    = lane_bu[VW-1] ? '0 : lane_bu;
                    n_pr    = lane_pr;
                    n_de    = lane_de;
                    n_state = CTL_DONE;
                end
            end
            CTL_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_W'({fmt_de, fmt_pr, fmt_bu});
                    n_out_user  = {r_status, r_flag};
                    n_state     = CTL_IDLE;
                end
            end
            default: begin
                n_state = CTL_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == CTL_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_cfg_ready     = 1'b1;

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == CTL_SCAN) |-> ((r_seg <= last) && (r_seg != '0)))
        else $error("segment search ran past the last breakpoint");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|lane_done) |-> (&lane_done))
        else $error("interpolation lanes finished on different cycles");

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (t_status'(o_m_axis_tuser[2:1]) != STAT_QUERY))
        |-> ((o_m_axis_tdata == '0) && !o_m_axis_tuser[0]))
        else $error("write result carries data or range flag");

endmodule

`default_nettype wire

// ===== tb/fluence_table_interpolator_unit_test.sv =====
// fluence_table_interpolator_unit_test: self-checking bench for the breakpoint table
// drives table writes, lookups and point-count changes through the streaming ports
// depends on fluti_pkg and fluence_table_interpolator_unit

module fluence_table_interpolator_unit_test;
    import fluti_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW       = DEF_VALUE_WIDTH;
    localparam int S_W      = ((IDX_W + 5 * VW + 7) / 8) * 8;
    localparam int M_W      = ((3 * VW + 7) / 8) * 8;
    localparam int FL_LSB   = IDX_W;
    localparam int PR_LSB   = IDX_W + VW;
    localparam int DE_LSB   = IDX_W + 2 * VW;
    localparam int BU_LSB   = IDX_W + 3 * VW;
    localparam int Q_LSB    = IDX_W + 4 * VW;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 120;
    localparam logic [31:0] V_MIN = 32'h8000_0000;
    localparam logic [31:0] V_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] burnup;
        logic signed [31:0] production;
        logic signed [31:0] destruction;
        logic               beyond;
        t_status            status;
    } t_answer;

    class fluence_lookup_board;
        logic signed [31:0] fl_tab [DEF_POINTS];
        logic signed [31:0] pr_tab [DEF_POINTS];
        logic signed [31:0] de_tab [DEF_POINTS];
        logic signed [31:0] bu_tab [DEF_POINTS];
        logic [CNT_W-1:0]   count_reg;
        t_answer            due_answers [$];
        int errors, writes, rejects, lookups, settings;

        function new();
            for (int i = 0; i < DEF_POINTS; i++) begin
                fl_tab[i] = '0;
                pr_tab[i] = '0;
                de_tab[i] = '0;
                bu_tab[i] = '0;
            end
            count_reg = CNT_RESET;
            errors = 0;
            writes = 0;
            rejects = 0;
            lookups = 0;
            settings = 0;
        endfunction

        static function logic [31:0] sat32(longint v);
            if (v > longint'(signed'(V_MAX))) return V_MAX;
            if (v < longint'(signed'(V_MIN))) return V_MIN;
            return 32'(v);
        endfunction

        static function int used_points(logic [CNT_W-1:0] c);
            if (c < CNT_MIN) return int'(CNT_MIN);
            if (c > DEF_POINTS) return DEF_POINTS;
            return int'(c);
        endfunction

        function longint blend(longint y0, longint y1, longint x0, longint x1, longint q);
            longint dy, dq, dx, m;
            logic [63:0] ady, adq, adx;
            logic [127:0] prod, quo;
            bit neg;
            dy = y1 - y0;
            dq = q - x0;
            dx = x1 - x0;
            if (dx == 0) return y0;
            ady = dy < 0 ? -dy : dy;
            adq = dq < 0 ? -dq : dq;
            adx = dx < 0 ? -dx : dx;
            prod = {64'b0, ady} * {64'b0, adq};
            quo = prod / {64'b0, adx};
            if (quo > (128'd1 << 62)) m = longint'(64'h4000_0000_0000_0000);
            else m = longint'(quo[63:0]);
            neg = ((dy < 0) != (dq < 0)) != (dx < 0);
            return longint'(signed'(sat32(neg ? y0 - m : y0 + m)));
        endfunction

        function t_answer lookup(bit cmd, logic [S_W-1:0] item);
            t_answer a;
            int n, last, s, idx;
            logic signed [31:0] q;
            longint bu, pr, de;
            a = '0;
            n = used_points(count_reg);
            last = n - 1;
            if (cmd == CMD_WRITE) begin
                idx = int'(item[IDX_W-1:0]);
                if (idx < n) begin
                    fl_tab[idx] = item[FL_LSB +: VW];
                    pr_tab[idx] = item[PR_LSB +: VW];
                    de_tab[idx] = item[DE_LSB +: VW];
                    bu_tab[idx] = item[BU_LSB +: VW];
                    a.status = STAT_WRITE;
                    writes++;
                end else begin
                    a.status = STAT_RANGE;
                    rejects++;
                end
            end else begin
                q = item[Q_LSB +: VW];
                a.status = STAT_QUERY;
                a.beyond = q >= fl_tab[last];
                lookups++;
                if (a.beyond) begin
                    bu = bu_tab[last];
                    pr = pr_tab[last];
                    de = de_tab[last];
                end else begin
                    s = 1;
                    while (s < last && fl_tab[s] <= q) s++;
                    bu = blend(bu_tab[s-1], bu_tab[s], fl_tab[s-1], fl_tab[s], q);
                    pr = blend(pr_tab[s-1], pr_tab[s], fl_tab[s-1], fl_tab[s], q);
                    de = blend(de_tab[s-1], de_tab[s], fl_tab[s-1], fl_tab[s], q);
                    if (bu < 0) bu = 0;
                end
                if (q <= 0) bu = 0;
                if (q < 0) begin
                    pr = 0;
                    de = 0;
                end
                a.burnup = 32'(bu);
                a.production = 32'(pr);
                a.destruction = 32'(de);
            end
            return a;
        endfunction

        function void set_count(logic [CNT_W-1:0] v);
            count_reg = v;
            settings++;
        endfunction

        function void take_item(bit cmd, logic [S_W-1:0] item);
            due_answers.insert(due_answers.size(), lookup(cmd, item));
        endfunction

        function int pending();
            return due_answers.size();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_answer(logic [M_W-1:0] data, logic [2:0] user);
            t_answer want;
            if (due_answers.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual %h %h",
                         $time, data, user);
                return;
            end
            want = due_answers.pop_front();
            compare_field("burnup_out", want.burnup, data[0 +: VW]);
            compare_field("production_out", want.production, data[VW +: VW]);
            compare_field("destruction_out", want.destruction, data[2*VW +: VW]);
            compare_field("beyond_range", 32'(want.beyond), 32'(user[0]));
            compare_field("status", 32'(want.status), 32'(user[2:1]));
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_valid = 1'b0;
    logic [S_W-1:0]   s_data = '0;
    logic             s_user = 1'b0;
    logic             m_ready = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [CNT_W-1:0] cfg_data = '0;
    wire              s_ready;
    wire              m_valid;
    wire  [M_W-1:0]   m_data;
    wire  [2:0]       m_user;
    wire              cfg_ready;

    fluence_lookup_board sb;
    logic signed [31:0] stim_fl [DEF_POINTS];
    int cur_n = 2;
    int items_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;

    fluence_table_interpolator_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            sb.check_answer(m_data, m_user);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [S_W-1:0] pack_item(logic [3:0] idx, logic [31:0] fl,
                                                 logic [31:0] pr, logic [31:0] de,
                                                 logic [31:0] bu, logic [31:0] q);
        logic [S_W-1:0] item;
        item = '0;
        item[IDX_W-1:0] = idx;
        item[FL_LSB +: VW] = fl;
        item[PR_LSB +: VW] = pr;
        item[DE_LSB +: VW] = de;
        item[BU_LSB +: VW] = bu;
        item[Q_LSB +: VW] = q;
        return item;
    endfunction

    function automatic logic [31:0] rand_value();
        if ($urandom_range(9) < 3) return $urandom;
        return 32'(longint'($urandom_range(32'h0080_0000)) - longint'(32'h0040_0000));
    endfunction

    function automatic logic [31:0] pick_query(int n);
        int r, i;
        longint lo, hi, q;
        r = $urandom_range(99);
        if (r < 15) begin
            return $urandom;
        end else if (r < 25) begin
            case ($urandom_range(4))
                0: q = 0;
                1: q = -1;
                2: q = 1;
                3: q = longint'(signed'(V_MIN));
                default: q = longint'(V_MAX);
            endcase
        end else if (r < 45) begin
            i = $urandom_range(n - 1);
            q = longint'(stim_fl[i]) + longint'($urandom_range(2)) - 1;
        end else if (r < 55) begin
            q = longint'(stim_fl[0]) - longint'($urandom_range(32'h0010_0000, 1));
        end else begin
            i = $urandom_range(n - 2);
            lo = stim_fl[i];
            hi = stim_fl[i+1];
            q = hi > lo ? lo + longint'($urandom) % (hi - lo) : lo;
        end
        return fluence_lookup_board::sat32(q);
    endfunction

    task automatic send_item(bit cmd, logic [S_W-1:0] item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        s_user <= cmd;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        sb.take_item(cmd, item);
        items_sent++;
    endtask

    task automatic write_point(int idx, logic [31:0] fl, logic [31:0] pr,
                               logic [31:0] de, logic [31:0] bu);
        send_item(CMD_WRITE, pack_item(4'(idx), fl, pr, de, bu, $urandom));
        if (idx < cur_n) stim_fl[idx] = fl;
    endtask

    task automatic query_at(logic [31:0] q);
        send_item(CMD_QUERY, pack_item(4'($urandom_range(15)), $urandom, $urandom,
                                       $urandom, $urandom, q));
    endtask

    task automatic set_count(logic [CNT_W-1:0] v);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_count(v);
        cfg_valid <= 1'b0;
        cur_n = fluence_lookup_board::used_points(v);
    endtask

    task automatic run_round();
        int v, n, r, i, k, nq;
        bit wide, sorted, rev;
        longint acc, stepmax;
        logic [31:0] fl [DEF_POINTS];
        r = $urandom_range(99);
        if (r < 8) v = $urandom_range(1);
        else if (r < 16) v = $urandom_range(31, 17);
        else if (r < 26) v = DEF_POINTS;
        else v = $urandom_range(8, 2);
        set_count(CNT_W'(v));
        n = cur_n;
        sorted = $urandom_range(99) < 85;
        wide = $urandom_range(3) == 0;
        if (wide) begin
            acc = longint'(signed'(V_MIN)) + longint'($urandom_range(32'h4000_0000));
            stepmax = longint'(64'd4294967295) / n;
        end else begin
            acc = longint'($urandom_range(32'h0010_0000)) - longint'(32'h0008_0000);
            stepmax = longint'(32'h0008_0000);
        end
        for (i = 0; i < n; i++) begin
            if (sorted) begin
                fl[i] = fluence_lookup_board::sat32(acc);
                acc += 1 + longint'($urandom) % stepmax;
            end else if (i > 0 && $urandom_range(3) == 0) begin
                fl[i] = fl[i-1];
            end else begin
                fl[i] = 32'(longint'($urandom_range(32'h0010_0000)) - longint'(32'h0008_0000));
            end
        end
        rev = ($urandom_range(1) == 1);
        for (k = 0; k < n; k++) begin
            i = rev ? n - 1 - k : k;
            if (n < DEF_POINTS && $urandom_range(9) == 0) begin
                write_point($urandom_range(15, n), $urandom, $urandom, $urandom, $urandom);
            end
            write_point(i, fl[i], rand_value(), rand_value(), rand_value());
        end
        nq = $urandom_range(20, 6);
        repeat (nq) begin
            r = $urandom_range(99);
            if (r < 5) begin
                write_point($urandom_range(n - 1), pick_query(n), rand_value(),
                            rand_value(), rand_value());
            end else if (r < 9) begin
                write_point($urandom_range(15), $urandom, $urandom, $urandom, $urandom);
            end else begin
                query_at(pick_query(n));
            end
        end
    endtask

    initial begin
        int phase_end;
        sb = new();
        for (int i = 0; i < DEF_POINTS; i++) stim_fl[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-scale two-point table at the reset count, two rejected writes, then lookups at the extremes
        write_point(0, V_MIN, V_MAX, 32'h0, V_MIN);
        write_point(1, V_MAX, V_MIN, 32'hFFFF_FFFF, V_MAX);
        write_point(2, $urandom, $urandom, $urandom, $urandom);
        write_point(15, V_MAX, V_MAX, V_MAX, V_MAX);
        query_at(V_MIN);
        query_at(32'hFFFF_FFFF);
        query_at(32'h0);
        query_at(32'h1);
        query_at(32'h4000_0000);
        query_at(V_MAX - 1);
        query_at(V_MAX);

        // zero-width first segment
        set_count(CNT_W'(3));
        write_point(0, 32'h0064_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        write_point(1, 32'h0064_0000, 32'h0005_0000, 32'hFFFA_0000, 32'h0007_0000);
        write_point(2, 32'h00C8_0000, 32'h0009_0000, 32'h000A_0000, 32'h000B_0000);
        query_at(32'h0032_0000);
        query_at(32'h0096_0000);

        // unsorted table, search runs to the last point; below-first extrapolation
        set_count(CNT_W'(4));
        write_point(0, 32'h0014_0000, 32'h0010_0000, 32'h0020_0000, 32'h0000_8000);
        write_point(1, 32'h0064_0000, 32'h0030_0000, 32'h0008_0000, 32'h0040_0000);
        write_point(2, 32'h0032_0000, 32'hFFF0_0000, 32'h0050_0000, 32'h0010_0000);
        write_point(3, 32'h00C8_0000, 32'h0070_0000, 32'hFF80_0000, 32'h0100_0000);
        query_at(32'h0096_0000);
        query_at(32'h000A_0000);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            phase_end = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < phase_end) run_round();
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d stored writes, %0d rejected writes and %0d lookups",
                 sb.writes, sb.rejects, sb.lookups);
        $display("over %0d point-count settings under four idle and stall mixes",
                 sb.settings);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/fluti_pkg.sv
src/fluti_ram.sv
src/fluti_interp.sv
src/fluence_table_interpolator_unit.sv
tb/fluence_table_interpolator_unit_test.sv
